// ===== src/nrb_pkg.sv =====
// Shared types and constants for the nth root bisection block.
`timescale 1ns / 1ps
`default_nettype none

package nrb_pkg;

  // Word widths of the fixed point format and of the search counters.
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = 48;
  localparam int DEG_W   = 4;
  localparam int STEP_W  = 10;
  localparam int TOL_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // The power is built from two halves of this width on one multiplier.
  localparam int HALF_W  = ACC_W / 2;
  localparam int PROD_W  = DATA_W + HALF_W;
  localparam int FULL_W  = DATA_W + ACC_W;

  // One in Q16.16 and the saturated power.
  localparam logic [DATA_W-1:0] ONE_Q = DATA_W'(1) << FRAC_W;
  localparam logic [ACC_W-1:0]  ACC_TOP = '1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd1;
  localparam logic [STEP_W-1:0] LIMIT_RESET = 10'd64;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIDPT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_EVAL,
    ST_REPORT
  } state_t;

  // Configuration values as seen by the datapath.
  typedef struct packed {
    logic [TOL_W-1:0]  tolerance;
    logic [STEP_W-1:0] iteration_limit;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic midpt;
    logic mul_lo;
    logic mul_hi;
    logic eval;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic deg_zero;
    logic mul_last;
    logic stop;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== src/nrb_cfg.sv =====
// Configuration registers of the nth root bisection block.
`timescale 1ns / 1ps
`default_nettype none

module nrb_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [nrb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [nrb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output nrb_pkg::cfg_t                         cfg
);
  import nrb_pkg::*;

  logic [TOL_W-1:0]  tolerance;
  logic [STEP_W-1:0] iteration_limit;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register file decode.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance       <= TOL_RESET;
      iteration_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TOLERANCE:  tolerance       <= cfg_data[TOL_W-1:0];
        CFG_ITER_LIMIT: iteration_limit <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.tolerance       = tolerance;
  assign cfg.iteration_limit = iteration_limit;

endmodule

`default_nettype wire

// ===== src/nrb_ctrl.sv =====
// Sequencing state machine of the nth root bisection block.
`timescale 1ns / 1ps
`default_nettype none

module nrb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output logic               done,
  output nrb_pkg::dp_cmd_t   cmd,
  input  wire nrb_pkg::dp_status_t status
);
  import nrb_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && !busy;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: midpoint, the chain of multiplications, then evaluation.
  always_comb begin
    state_next = state;
    unique case (state) inside
      ST_IDLE, ST_REPORT: begin
        state_next = start ? ST_MIDPT : ST_IDLE;
      end
      ST_MIDPT: begin
        state_next = status.deg_zero ? ST_EVAL : ST_MUL_LO;
      end
      ST_MUL_LO: begin
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        state_next = status.mul_last ? ST_EVAL : ST_MUL_LO;
      end
      ST_EVAL: begin
        state_next = status.stop ? ST_REPORT : ST_MIDPT;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    busy       = 1'b1;
    done       = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_REPORT: begin
        busy = 1'b0;
        done = 1'b1;
      end
      ST_MIDPT:  cmd.midpt  = 1'b1;
      ST_MUL_LO: cmd.mul_lo = 1'b1;
      ST_MUL_HI: cmd.mul_hi = 1'b1;
      ST_EVAL:   cmd.eval   = 1'b1;
      default: ;
    endcase
    cmd.load = accept;
  end

`ifndef SYNTH
  // A result word follows only the evaluation that ended the search.
  a_done_after_eval: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EVAL && status.stop))
    else $error("result word without a finishing evaluation");

  // An accepted word always starts with a midpoint step.
  a_accept_to_midpt: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_MIDPT)
    else $error("accepted word did not start a search");
`endif

endmodule

`default_nettype wire

// ===== src/nrb_dp.sv =====
// Bisection datapath: interval, midpoint, shared multiplier and compare.
`timescale 1ns / 1ps
`default_nettype none

module nrb_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire nrb_pkg::dp_cmd_t                     cmd,
  output nrb_pkg::dp_status_t                       status,
  input  wire nrb_pkg::cfg_t                        cfg,
  input  wire logic signed [nrb_pkg::DATA_W-1:0]    radicand,
  input  wire logic [nrb_pkg::DEG_W-1:0]            degree,
  output logic signed [nrb_pkg::DATA_W-1:0]         root,
  output logic                                      converged
);
  import nrb_pkg::*;

  // Search state.
  logic              neg;
  logic [DATA_W-1:0] mag;
  logic [DEG_W-1:0]  deg;
  logic [DATA_W-1:0] interval_low;
  logic [DATA_W-1:0] interval_high;
  logic [DATA_W-1:0] candidate;
  logic [ACC_W-1:0]  power_accumulator;
  logic [PROD_W-1:0] partial;
  logic [STEP_W-1:0] step_count;
  logic [DEG_W-1:0]  multiply_count;

  logic [DATA_W-1:0] rad_u;
  logic [DATA_W-1:0] mag_next;
  logic [DATA_W-1:0] mid_next;
  logic [HALF_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [FULL_W-1:0] full;
  logic [ACC_W-1:0]  power_next;
  logic [ACC_W-1:0]  mag_x;
  logic              above;
  logic [ACC_W-1:0]  diff;
  logic              conv;
  logic [DATA_W-1:0] high_next;
  logic [DATA_W-1:0] low_next;
  logic              collapse;
  logic [STEP_W-1:0] steps_next;
  logic [STEP_W-1:0] limit_eff;

  // Magnitude of the radicand; the most negative value stays 2^31.
  assign rad_u    = radicand;
  assign mag_next = rad_u[DATA_W-1] ? (~rad_u + DATA_W'(1)) : rad_u;

  // Midpoint of the current interval.
  assign mid_next = interval_low + ((interval_high - interval_low) >> 1);

  // One multiplier, fed the low half of the power and then the high half.
  assign mul_b = cmd.mul_hi ? power_accumulator[ACC_W-1:HALF_W]
                            : power_accumulator[HALF_W-1:0];
  assign mul_p = PROD_W'(candidate) * PROD_W'(mul_b);
  assign full  = {mul_p, {HALF_W{1'b0}}} + FULL_W'(partial);

  // Truncate to Q32.16 and saturate anything past the accumulator.
  assign power_next = (full[FULL_W-1:ACC_W+FRAC_W] != '0) ? ACC_TOP
                                                         : full[ACC_W+FRAC_W-1:FRAC_W];

  // Compare the power with the magnitude and narrow the interval.
  assign mag_x      = ACC_W'(mag);
  assign above      = power_accumulator > mag_x;
  assign diff       = above ? (power_accumulator - mag_x) : (mag_x - power_accumulator);
  assign conv       = diff <= ACC_W'(cfg.tolerance);
  assign high_next  = above ? candidate : interval_high;
  assign low_next   = (!above && diff != '0) ? candidate : interval_low;
  assign collapse   = (high_next - low_next) <= DATA_W'(1);
  assign steps_next = step_count + STEP_W'(1);
  assign limit_eff  = (cfg.iteration_limit == '0) ? STEP_W'(1) : cfg.iteration_limit;

  assign status.deg_zero = deg == '0;
  assign status.mul_last = (multiply_count + DEG_W'(1)) == deg;
  assign status.stop     = conv || collapse || (steps_next >= limit_eff);

  // Search registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      neg               <= 1'b0;
      mag               <= '0;
      deg               <= '0;
      interval_low      <= '0;
      interval_high     <= '0;
      candidate         <= '0;
      power_accumulator <= '0;
      partial           <= '0;
      step_count        <= '0;
      multiply_count    <= '0;
    end else begin
      if (cmd.load) begin
        neg            <= rad_u[DATA_W-1];
        mag            <= mag_next;
        deg            <= degree;
        interval_low   <= '0;
        interval_high  <= (mag_next > ONE_Q) ? mag_next : ONE_Q;
        step_count     <= '0;
      end
      if (cmd.midpt) begin
        candidate         <= mid_next;
        power_accumulator <= ACC_W'(ONE_Q);
        multiply_count    <= '0;
      end
      if (cmd.mul_lo) begin
        partial <= mul_p;
      end
      if (cmd.mul_hi) begin
        power_accumulator <= power_next;
        multiply_count    <= multiply_count + DEG_W'(1);
      end
      if (cmd.eval) begin
        interval_high <= high_next;
        interval_low  <= low_next;
        step_count    <= steps_next;
      end
    end
  end

  // Result word, held until the next search ends.
  always_ff @(posedge clk) begin
    if (rst) begin
      root      <= '0;
      converged <= 1'b0;
    end else if (cmd.eval && status.stop) begin
      root      <= neg ? -$signed(candidate) : $signed(candidate);
      converged <= conv;
    end
  end

`ifndef SYNTH
  // A new midpoint is only taken on an interval wider than one LSB.
  a_interval_open: assert property (@(posedge clk) disable iff (rst)
    cmd.midpt |-> (interval_high - interval_low) > DATA_W'(1))
    else $error("midpoint taken on a collapsed interval");

  // The search never evaluates past its step limit.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.eval |-> step_count < limit_eff)
    else $error("evaluation beyond the step limit");
`endif

endmodule

`default_nettype wire

// ===== src/nth_root_bisection.sv =====
// Top level of the nth root bisection block.
//
//   channel   ports                                   handshake
//   input     start, busy, radicand, degree           taken when start && !busy
//   result    done, root, converged                   one cycle strobe, no stall
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data   taken when valid && ready
//
// A word runs one midpoint step, n multiply steps and one evaluation per
// bisection step, where n is the degree, until the search stops.
// Each power is formed by n multiplications on one
// shared 32 x 24 bit multiplier, each a low half then a high half. A new word may be accepted
// in the cycle that carries done. Reset is synchronous and restores the
// configuration defaults; the result side cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module nth_root_bisection (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [nrb_pkg::DATA_W-1:0]    radicand,
  input  wire logic [nrb_pkg::DEG_W-1:0]            degree,
  output logic                                      done,
  output logic signed [nrb_pkg::DATA_W-1:0]         root,
  output logic                                      converged,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [nrb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [nrb_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import nrb_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers.
  nrb_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer.
  nrb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  // Arithmetic.
  nrb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg       (cfg),
    .radicand  (radicand),
    .degree    (degree),
    .root      (root),
    .converged (converged)
  );

endmodule

`default_nettype wire

// ===== tb/nth_root_bisection_test.sv =====
// Self-checking testbench for the nth root bisection block.
`timescale 1ns / 1ps

module nth_root_bisection_test;
  import nrb_pkg::*;

  // An idle stretch this long means the block has hung; it is longer than
  // the slowest word and the longest sender gap.
  localparam int WATCHDOG_LIMIT = 10000;
  // Quiet time after the last result, about one worst case word.
  localparam int END_CYCLES = 1100;

  // One queued word or one queued register write.
  typedef struct {
    bit                      is_write;
    logic [CFG_IDX_W-1:0]    reg_index;
    logic [CFG_DATA_W-1:0]   reg_value;
    logic signed [DATA_W-1:0] value;
    logic [DEG_W-1:0]        deg;
  } pending_op_t;

  // Predicted result, with the word that caused it for reporting.
  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [DEG_W-1:0]         deg;
    logic signed [DATA_W-1:0] root;
    logic                     converged;
  } root_expect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [DATA_W-1:0] radicand = '0;
  logic [DEG_W-1:0] degree = '0;
  logic done;
  logic signed [DATA_W-1:0] root;
  logic converged;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_TOLERANCE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pending_op_t pending_ops[$];
  root_expect_t expected_roots[$];
  logic [TOL_W-1:0] tol_cfg;
  logic [STEP_W-1:0] limit_cfg;
  int mismatches = 0;
  int idle_cycles = 0;
  int words_in_flight = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  nth_root_bisection dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .radicand  (radicand),
    .degree    (degree),
    .done      (done),
    .root      (root),
    .converged (converged),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bisection search for the signed root under the given settings.
  function automatic root_expect_t bisect_root(input logic [DATA_W-1:0] x,
                                               input logic [DEG_W-1:0] n,
                                               input logic [TOL_W-1:0] tol,
                                               input logic [STEP_W-1:0] lim);
    bit [DATA_W-1:0] mag;
    bit neg;
    bit [ACC_W-1:0] lo, hi, mid, pw, diff;
    bit [95:0] prod;
    int unsigned steps, cap;
    bit finished;
    root_expect_t r;
    neg = x[DATA_W-1];
    mag = neg ? -x : x;
    cap = (lim == 0) ? 1 : 32'(lim);
    lo = '0;
    hi = (mag > ONE_Q) ? ACC_W'(mag) : ACC_W'(ONE_Q);
    mid = '0;
    steps = 0;
    finished = 1'b0;
    r.converged = 1'b0;
    while (!finished) begin
      mid = lo + ((hi - lo) >> 1);
      // Raise the midpoint to the degree; each product truncates and saturates.
      pw = ACC_W'(ONE_Q);
      for (int k = 0; k < n; k++) begin
        prod = 96'(pw) * 96'(mid);
        pw = (prod[95:FRAC_W] > 80'(ACC_TOP)) ? ACC_TOP : prod[ACC_W+FRAC_W-1:FRAC_W];
      end
      diff = (pw >= ACC_W'(mag)) ? pw - ACC_W'(mag) : ACC_W'(mag) - pw;
      steps++;
      if (pw > ACC_W'(mag)) begin
        hi = mid;
      end else if (diff != 0) begin
        lo = mid;
      end
      if (diff <= tol) begin
        r.converged = 1'b1;
        finished = 1'b1;
      end else if (hi - lo <= 1 || steps >= cap) begin
        finished = 1'b1;
      end
    end
    r.value = x;
    r.deg = n;
    r.root = neg ? -mid[DATA_W-1:0] : mid[DATA_W-1:0];
    return r;
  endfunction

  task automatic add_word(input logic [DATA_W-1:0] x, input logic [DEG_W-1:0] n);
    pending_op_t op;
    op.is_write = 1'b0;
    op.reg_index = CFG_TOLERANCE;
    op.reg_value = '0;
    op.value = x;
    op.deg = n;
    pending_ops.push_back(op);
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    pending_op_t op;
    op.is_write = 1'b1;
    op.reg_index = idx;
    op.reg_value = data;
    op.value = '0;
    op.deg = '0;
    pending_ops.push_back(op);
  endtask

  // Driver: sends words in bursts with random gaps; register writes wait
  // until every word sent so far has produced its result.
  always @(posedge clk) begin
    pending_op_t op;
    logic next_start, next_cfg;
    int flight;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      words_in_flight = 0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      next_start = start;
      next_cfg = cfg_valid;
      flight = words_in_flight + ((start && !busy) ? 1 : 0) - (done ? 1 : 0);
      if (start && !busy) begin
        next_start = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(20, 60);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 6);
            case ($urandom_range(0, 9)) inside
              0: gap_left = $urandom_range(40, 1200);
              1, 2: gap_left = $urandom_range(5, 40);
              default: gap_left = $urandom_range(0, 4);
            endcase
          end
        end
      end else if (gap_left > 0) begin
        gap_left--;
      end
      if (cfg_valid && cfg_ready) next_cfg = 1'b0;
      if (!next_start && !next_cfg && gap_left == 0 && pending_ops.size() > 0) begin
        if (!pending_ops[0].is_write) begin
          op = pending_ops.pop_front();
          radicand <= op.value;
          degree <= op.deg;
          next_start = 1'b1;
        end else if (flight <= 0 && !busy) begin
          op = pending_ops.pop_front();
          cfg_index <= op.reg_index;
          cfg_data <= op.reg_value;
          next_cfg = 1'b1;
        end
      end
      start <= next_start;
      cfg_valid <= next_cfg;
      words_in_flight = flight;
    end
  end

  // Monitor: tracks register writes, predicts each accepted word and checks
  // each result strobe against the oldest prediction.
  always @(posedge clk) begin
    root_expect_t want;
    if (rst) begin
      tol_cfg = TOL_RESET;
      limit_cfg = LIMIT_RESET;
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (cfg_valid && cfg_ready) begin
        idle_cycles = 0;
        if (cfg_index == CFG_TOLERANCE) tol_cfg = cfg_data[TOL_W-1:0];
        else if (cfg_index == CFG_ITER_LIMIT) limit_cfg = cfg_data[STEP_W-1:0];
      end
      if (start && !busy) begin
        idle_cycles = 0;
        expected_roots.push_back(bisect_root(radicand, degree, tol_cfg, limit_cfg));
      end
      if (done) begin
        idle_cycles = 0;
        if (expected_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: root %h converged %b", root, converged);
        end else begin
          want = expected_roots.pop_front();
          if (root !== want.root || converged !== want.converged) begin
            mismatches++;
            if (mismatches <= 10)
              $display("radicand %h degree %0d: expected root %h converged %b, got %h %b",
                       want.value, want.deg, want.root, want.converged, root, converged);
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_roots.size());
        $display("nth_root_bisection: mismatch");
        $finish;
      end
    end
  end

  // Stimulus: directed corner words, then random phases with new settings.
  initial begin
    int unsigned n, k, kmax, pick;
    logic [DATA_W-1:0] x;
    logic [CFG_DATA_W-1:0] lim_word;

    // Default settings: zero, unity, exact roots, signs, saturation,
    // the most negative value, tiny values and degree zero.
    add_word(32'h0000_0000, 4'd1);
    add_word(32'h0001_0000, 4'd1);
    add_word(32'h0004_0000, 4'd2);
    add_word(32'hFFF8_0000, 4'd3);
    add_word(32'hFFFC_0000, 4'd2);
    add_word(32'h7FFF_FFFF, 4'd15);
    add_word(32'h7FFF_FFFF, 4'd1);
    add_word(32'h8000_0000, 4'd1);
    add_word(32'h8000_0000, 4'd15);
    add_word(32'h0000_0001, 4'd2);
    add_word(32'hFFFF_FFFF, 4'd3);
    add_word(32'h0003_0000, 4'd0);
    add_word(32'h0000_8000, 4'd4);

    // Zero tolerance and a step limit of 1000: searches run to collapse.
    add_write(CFG_TOLERANCE, 16'h0000);
    add_write(CFG_ITER_LIMIT, 16'd1000);
    add_word(32'h0002_0000, 4'd2);
    add_word(32'h8000_0000, 4'd7);
    add_word(32'h7FFF_FFFF, 4'd15);

    // Widest tolerance and a step limit of zero, which acts as one step.
    add_write(CFG_TOLERANCE, 16'hFFFF);
    add_write(CFG_ITER_LIMIT, 16'hFC00);
    add_word(32'h1234_5678, 4'd5);
    add_word(32'hFFFF_0000, 4'd1);
    add_word(32'h0000_0000, 4'd0);

    // Random phases, each under fresh settings.
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 5))
        0: add_write(CFG_TOLERANCE, 16'h0000);
        1: add_write(CFG_TOLERANCE, 16'h0001);
        2: add_write(CFG_TOLERANCE, 16'hFFFF);
        3: add_write(CFG_TOLERANCE, 16'($urandom_range(0, 15)));
        default: add_write(CFG_TOLERANCE, 16'($urandom));
      endcase
      // The bits above the limit field are random and must be dropped.
      lim_word = 16'($urandom);
      case ($urandom_range(0, 5))
        0: lim_word[STEP_W-1:0] = '0;
        1: lim_word[STEP_W-1:0] = 10'd1;
        2: lim_word[STEP_W-1:0] = 10'd1000;
        3: lim_word[STEP_W-1:0] = 10'h3FF;
        4: lim_word[STEP_W-1:0] = 10'($urandom_range(2, 40));
        default: ;
      endcase
      add_write(CFG_ITER_LIMIT, lim_word);

      for (int i = 0; i < 113; i++) begin
        n = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 15);
        pick = $urandom_range(0, 9);
        case (pick) inside
          0, 1, 2: x = $urandom;
          3, 4: x = $urandom_range(0, 32'h0010_0000);
          5, 6: begin
            // Exact powers of an integer root, so that matches can be exact.
            n = $urandom_range(1, 15);
            kmax = 1;
            if (n == 1) kmax = 32767;
            else while (longint'(kmax + 1) ** n < 32768) kmax++;
            k = $urandom_range(1, kmax);
            x = DATA_W'((longint'(k) ** n) << FRAC_W);
          end
          7: begin
            case ($urandom_range(0, 6))
              0: x = 32'h0000_0000;
              1: x = 32'h0000_0001;
              2: x = 32'hFFFF_FFFF;
              3: x = 32'h7FFF_FFFF;
              4: x = 32'h8000_0000;
              5: x = 32'h0001_0000;
              default: x = 32'hFFFF_0000;
            endcase
          end
          default: x = $urandom_range(0, 32'h0100_0000);
        endcase
        if (pick >= 3 && pick != 7 && $urandom_range(0, 1) == 1) x = -x;
        add_word(x, 4'(n));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, every result back, then a quiet stretch.
    while (pending_ops.size() != 0 || start || cfg_valid || expected_roots.size() != 0)
      @(negedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("nth_root_bisection: match");
    end else begin
      $display("nth_root_bisection: mismatch");
    end
    $finish;
  end

endmodule
